/* rtl/fpa_pkg.sv */
package fpa_pkg;

  // Fixed field widths of the item and result channels.
  localparam int ACTION_W = 1;
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'd1;

  // Placement rules. The unused code behaves as first fit.
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_LOAD    = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic capture;
    logic scan_issue;
    logic load_wr;
    logic update_wr;
    logic refuse;
    logic out_load;
  } fpa_cmd_t;

  typedef struct packed {
    logic in_is_request;
    logic count_zero;
    logic scan_last;
    logic out_free;
  } fpa_stat_t;

endpackage

/* rtl/fpa_item_if.sv */
interface fpa_item_if
  import fpa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output action, output slot, output amount, input ready);
  modport sink   (input valid, input action, input slot, input amount, output ready);
endinterface

/* rtl/fpa_result_if.sv */
interface fpa_result_if
  import fpa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [SLOT_W-1:0]   chosen_slot;
  logic [AMOUNT_W-1:0] remaining;

  modport source (output valid, output granted, output chosen_slot, output remaining,
                  input ready);
  modport sink   (input valid, input granted, input chosen_slot, input remaining,
                  output ready);
endinterface

/* rtl/fpa_ctrl.sv */
module fpa_ctrl
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fpa_stat_t stat,
  output fpa_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = stat.in_is_request ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        if (stat.count_zero) begin
          cmd.refuse = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.scan_issue = 1'b1;
          if (stat.scan_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      // The last entry read is compared here; the pick is final afterwards.
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update_wr = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !stat.out_free) |=> state_r == S_DONE)
    else $error("result left the controller while the output register was full");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_wr, cmd.update_wr, cmd.refuse, cmd.out_load, cmd.scan_issue}))
    else $error("controller issued conflicting commands");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_SCAN || state_r == S_LOAD))
    else $error("accepted request did not start a load or a scan");

endmodule

/* rtl/fpa_datapath.sv */
module fpa_datapath
  import fpa_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [AMOUNT_W-1:0]   in_amount,
  input  fpa_cmd_t              cmd,
  output fpa_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  output logic [SLOT_W-1:0]     out_chosen_slot,
  output logic [AMOUNT_W-1:0]   out_remaining
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [MODE_W-1:0]    fit_mode_r;
  logic [COUNT_W-1:0]   part_count_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SIZE_BITS-1:0] amt_r;

  logic [SIZE_BITS-1:0] mem [SLOTS];
  logic [SLOTS-1:0]     loaded_r;

  logic [CW-1:0]        scan_idx_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_loaded_r;
  logic                 cmp_vld_r;
  logic [IW-1:0]        cmp_idx_r;
  logic                 found_r;
  logic [IW-1:0]        pick_idx_r;
  logic [SIZE_BITS-1:0] pick_val_r;

  logic                 res_granted_r;
  logic [IW-1:0]        res_slot_r;
  logic [SIZE_BITS-1:0] res_rem_r;

  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [AMOUNT_W-1:0]  out_rem_r;

  logic [MW-1:0]        pc_w;
  logic [MW-1:0]        count_w;
  logic [CW-1:0]        count;
  logic                 slot_ok;
  logic [IW-1:0]        slot_idx;
  logic [IW-1:0]        scan_addr;
  logic [SIZE_BITS-1:0] entry_val;
  logic                 take;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] left_val;

  // Partition count above the table depth is clamped to the depth.
  assign pc_w      = MW'(part_count_r);
  assign count_w   = (pc_w > MW'(SLOTS)) ? MW'(SLOTS) : pc_w;
  assign count     = CW'(count_w);
  assign slot_ok   = int'(slot_r) < SLOTS;
  assign slot_idx  = IW'(slot_r);
  assign scan_addr = scan_idx_r[IW-1:0];
  assign left_val  = pick_val_r - amt_r;

  assign stat.in_is_request = (in_action == ACT_REQUEST);
  assign stat.count_zero    = (count == '0);
  assign stat.scan_last     = (scan_idx_r == CW'(count - CW'(1)));
  assign stat.out_free      = !out_valid_r || out_ready;

  // A partition that was never loaded holds zero.
  assign entry_val = rd_loaded_r ? rd_data_r : '0;

  always_comb begin
    take = 1'b0;
    if (cmp_vld_r && entry_val >= amt_r) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (fit_mode_r == FIT_BEST) begin
        take = entry_val < pick_val_r;
      end else if (fit_mode_r == FIT_WORST) begin
        take = entry_val > pick_val_r;
      end
    end
  end

  assign wr_en   = (cmd.load_wr && slot_ok) || (cmd.update_wr && found_r);
  assign wr_addr = cmd.load_wr ? slot_idx : pick_idx_r;
  assign wr_data = cmd.load_wr ? amt_r : left_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_issue) begin
      rd_data_r   <= mem[scan_addr];
      rd_loaded_r <= loaded_r[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= FIT_FIRST;
      part_count_r <= '0;
      loaded_r     <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      scan_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_FIT_MODE) begin
          fit_mode_r <= cfg_data[MODE_W-1:0];
        end else if (cfg_idx == REG_PART_COUNT) begin
          part_count_r <= cfg_data[COUNT_W-1:0];
        end
      end
      if (wr_en) begin
        loaded_r[wr_addr] <= 1'b1;
      end
      cmp_vld_r <= cmd.scan_issue;
      if (cmd.capture) begin
        found_r    <= 1'b0;
        scan_idx_r <= '0;
      end else begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (cmd.scan_issue) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r <= in_slot;
      amt_r  <= SIZE_BITS'(in_amount);
    end
    if (cmd.scan_issue) begin
      cmp_idx_r <= scan_addr;
    end
    if (take) begin
      pick_idx_r <= cmp_idx_r;
      pick_val_r <= entry_val;
    end
    if (cmd.load_wr) begin
      res_granted_r <= slot_ok;
      res_slot_r    <= slot_ok ? slot_idx : '0;
      res_rem_r     <= slot_ok ? amt_r : '0;
    end else if (cmd.update_wr) begin
      res_granted_r <= found_r;
      res_slot_r    <= found_r ? pick_idx_r : '0;
      res_rem_r     <= found_r ? left_val : '0;
    end else if (cmd.refuse) begin
      res_granted_r <= 1'b0;
      res_slot_r    <= '0;
      res_rem_r     <= '0;
    end
    if (cmd.out_load) begin
      out_granted_r <= res_granted_r;
      out_slot_r    <= SLOT_W'(res_slot_r);
      out_rem_r     <= AMOUNT_W'(res_rem_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_slot_r;
  assign out_remaining   = out_rem_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> (count != '0) && (scan_idx_r < count))
    else $error("scan read beyond the partitions in use");

  a_grant_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update_wr && found_r) |=> res_granted_r && (res_rem_r <= $past(pick_val_r)))
    else $error("granted request left more than the partition held");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before it was taken");

endmodule

/* rtl/fit_policy_partition_allocator.sv */
// Partition allocator with first, best and worst fit placement. A load request
// writes one partition's free size in its load state, and its result then
// goes to the output register. An allocation request reads the partitions
// in use one per cycle through the single read port of the size table, or,
// when partition_count is zero, reads none and is refused outright. The scan
// always covers every partition in use, whatever the placement rule. One
// request is worked on at a time, but the next one is accepted while a
// finished result still waits in the output register. The size table needs no
// clearing pass after reset: each entry carries a loaded flag that reset
// clears, and an entry never loaded reads as zero.
module fit_policy_partition_allocator
  import fpa_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fpa_item_if.sink              in_req,
  fpa_result_if.source          out_res
);

  fpa_cmd_t  cmd;
  fpa_stat_t stat;
  logic      in_ready;

  assign in_req.ready = in_ready;

  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpa_datapath #(
    .SLOTS     (SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_action       (in_req.action),
    .in_slot         (in_req.slot),
    .in_amount       (in_req.amount),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .out_granted     (out_res.granted),
    .out_chosen_slot (out_res.chosen_slot),
    .out_remaining   (out_res.remaining)
  );

endmodule
